// ----- src/ar4lsf_pkg.sv -----
// ----------------------------------------------------------------------------
// ar4lsf_pkg
// Shared widths and codes of the AR(4) least-squares fit block.
// ----------------------------------------------------------------------------
package ar4lsf_pkg;

  localparam int WINDOW_MAX = 256;
  localparam int AW         = $clog2(WINDOW_MAX);
  localparam int CW         = $clog2(WINDOW_MAX + 1);
  localparam int LAGS       = 4;
  localparam int QF         = 24;

  localparam int MAG_W  = 21;           // magnitude, 4 fraction bits
  localparam int SUM_W  = MAG_W + AW;   // window sum of magnitudes
  localparam int DEV_W  = 27;           // deviation, 8 fraction bits
  localparam int SQW    = 40;           // isqrt radicand
  localparam int MW     = 33;           // multiplier operand
  localparam int PW     = 2 * MW;       // multiplier product
  localparam int DNW    = 64;           // divider dividend / quotient
  localparam int DDW    = 32;           // divider divisor / remainder
  localparam int DCNT_W = $clog2(DNW);
  localparam int VAR_W  = 48;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_SHORT    = 2'd1,
    ST_SINGULAR = 2'd2
  } fit_status_t;

endpackage

// ----- src/ar4_least_squares_fit.sv -----
// ----------------------------------------------------------------------------
// ar4_least_squares_fit
// AR(4) least-squares fit over a window of accelerometer vector magnitudes.
// ----------------------------------------------------------------------------
//  channel  dir  signals                          request
//  in_      in   tvalid tready tdata[47:0] tlast  one 3-axis sample
//  out_     out  tvalid tready tdata[175:0]       one fit per window
//                tuser[2:0]
//
//  Each sample needs three squares on the shared multiplier,
//  then 20 steps of the bit-serial square root.
//  In a fit for N stored samples, the per-lag loops run on the shared
//  multiplier and the rest on the divider (mean, 14 pivot divisions, variance).
//  in_tready is high only while idle; a finished fit waits in the output
//  register, and the next window may load meanwhile. Reset is synchronous.
// ----------------------------------------------------------------------------
module ar4_least_squares_fit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // accel_x, accel_y, accel_z
  input  logic         in_tlast,   // last_sample
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [175:0] out_tdata,  // coeff_lag1..4, residual_variance
  output logic [2:0]   out_tuser   // fit_status, samples_dropped
);
  import ar4lsf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_ROOT_GO, S_ROOT_WAIT, S_FIT, S_MEAN, S_WRD, S_WCAP,
    S_NMUL, S_NACC, S_MAX, S_LEN, S_NORM, S_PIV, S_DIVGO, S_DIVWT, S_FROW,
    S_EMUL, S_ESUB, S_RMUL, S_RACC, S_RSQ, S_RSQA, S_VARGO, S_VARWT, S_OUT
  } state_t;

  state_t state_r;

  // sample path
  logic signed [15:0]   axis_r [3];
  logic                 last_r;
  logic [31:0]          sq_acc_r;
  logic [CW-1:0]        count_r;
  logic [SUM_W-1:0]     sum_r;
  logic                 ovf_r;

  // magnitude store
  logic [MAG_W-1:0]     mag_mem [WINDOW_MAX];
  logic [MAG_W-1:0]     mem_q_r;
  logic [CW-1:0]        rd_ptr_r;
  logic                 mem_we;

  // fit datapath
  logic [DEV_W-2:0]     mean_r;
  logic signed [DEV_W-1:0] win_r [5];
  logic signed [63:0]   mat_r [20];
  logic [4:0]           k_r;
  logic                 res_pass_r;
  logic [63:0]          top_r;
  logic [6:0]           len_r;
  logic [1:0]           i_r, row_r;
  logic [2:0]           col_r;
  logic signed [31:0]   piv_r, f_r;
  logic                 neg_r;
  logic signed [63:0]   res_r;
  logic [63:0]          acc_r;
  logic [VAR_W-1:0]     var_r;
  fit_status_t          status_r;

  // output register
  logic                 out_valid_r;
  logic [31:0]          out_coef_r [4];
  logic [VAR_W-1:0]     out_var_r;
  fit_status_t          out_status_r;
  logic                 out_drop_r;

  // shared units
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [63:0]   p64;
  logic                 div_start, div_done;
  logic [DNW-1:0]       div_num, div_quo;
  logic [DDW-1:0]       div_den, div_rem;
  logic                 sqrt_start, sqrt_done;
  logic [MAG_W-1:0]     sqrt_root;

  logic [4:0]           mat_addr;
  logic signed [63:0]   mat_rd;
  logic signed [DEV_W-1:0] dev_cap;
  logic [CW-1:0]        m_cnt;
  logic [CW-1:0]        m_half;
  logic [63:0]          var_full;
  logic [64:0]          acc_sum;
  logic [63:0]          rm;
  logic signed [31:0]   q_prod;
  logic signed [32:0]   e_diff;
  logic                 in_acc;

  function automatic logic [4:0] idx(input logic [1:0] r, input logic [2:0] c);
    if (c == 3'd4) begin
      return {3'b100, r};
    end
    return {1'b0, r, c[1:0]};
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] with_sign(input logic [63:0] m, input logic neg);
    if (neg) begin
      if (m >= 64'h8000_0000) begin
        return 32'sh8000_0000;
      end
      return -$signed(m[31:0]);
    end
    if (m > 64'h7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end
    return $signed(m[31:0]);
  endfunction

  function automatic logic signed [31:0] sat31(input logic signed [32:0] d);
    if (d > 33'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end
    if (d < -33'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return d[31:0];
  endfunction

  function automatic logic signed [63:0] normalize(input logic signed [63:0] v,
                                                   input logic [6:0] len);
    logic [63:0] m;
    logic [6:0]  sh;
    m = mag64(v);
    if (len > 7'd30) begin
      sh = len - 7'd30;
      m  = (m + (64'd1 << (sh - 7'd1))) >> sh;
    end else begin
      m = m << (7'd30 - len);
    end
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [MW-1:0] ext_dev(input logic signed [DEV_W-1:0] d);
    return {{(MW-DEV_W){d[DEV_W-1]}}, d};
  endfunction

  function automatic logic signed [MW-1:0] ext32(input logic signed [31:0] d);
    return {d[31], d};
  endfunction

  ar4lsf_mul u_mul (
    .clk     (clk),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .product (mul_p)
  );

  ar4lsf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  ar4lsf_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({sq_acc_r, 8'h00}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  assign p64       = mul_p[63:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign m_cnt     = count_r - CW'(LAGS);
  assign m_half    = m_cnt - (m_cnt >> 1);
  assign mat_rd    = mat_r[mat_addr];
  assign dev_cap   = $signed({2'b00, mem_q_r, 4'b0000}) - $signed({1'b0, mean_r});
  assign mem_we    = (state_r == S_ROOT_WAIT) && sqrt_done &&
                     (count_r < CW'(WINDOW_MAX));
  assign sqrt_start = (state_r == S_ROOT_GO);

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    div_start = 1'b0;
    div_num  = '0;
    div_den  = '0;
    mat_addr = k_r;
    rm       = (mag64(res_r) + (64'd1 << 27)) >> 28;
    q_prod   = with_sign((mag64(p64) + (64'd1 << (QF - 1))) >> QF, p64[63]);
    e_diff   = '0;
    case (state_r)
      S_SQ: begin
        if (k_r < 5'd3) begin
          mul_a = {{(MW-16){axis_r[k_r[1:0]][15]}}, axis_r[k_r[1:0]]};
          mul_b = {{(MW-16){axis_r[k_r[1:0]][15]}}, axis_r[k_r[1:0]]};
        end
      end
      S_FIT: begin
        div_start = (count_r > CW'(LAGS + 2));
        div_num   = (64'(sum_r) << 4) + 64'(count_r >> 1);
        div_den   = DDW'(count_r);
      end
      S_NMUL: begin
        if (k_r < 5'd16) begin
          mul_a = ext_dev(win_r[3'd3 - {1'b0, k_r[3:2]}]);
          mul_b = ext_dev(win_r[3'd3 - {1'b0, k_r[1:0]}]);
        end else begin
          mul_a = ext_dev(win_r[3'd3 - {1'b0, k_r[1:0]}]);
          mul_b = ext_dev(win_r[4]);
        end
      end
      S_PIV:   mat_addr = idx(i_r, {1'b0, i_r});
      S_DIVGO: begin
        mat_addr  = idx(i_r, col_r);
        div_start = 1'b1;
        div_num   = (64'(mag32(mat_rd[31:0])) << QF) + 64'(mag32(piv_r) >> 1);
        div_den   = mag32(piv_r);
      end
      S_DIVWT: mat_addr = idx(i_r, col_r);
      S_FROW:  mat_addr = idx(row_r, {1'b0, i_r});
      S_EMUL: begin
        mat_addr = idx(i_r, col_r);
        mul_a    = ext32(f_r);
        mul_b    = ext32(mat_rd[31:0]);
      end
      S_ESUB: begin
        mat_addr = idx(row_r, col_r);
        e_diff   = {mat_rd[31], mat_rd[31:0]} - {q_prod[31], q_prod};
      end
      S_RMUL: begin
        mat_addr = {3'b100, k_r[1:0]};
        mul_a    = ext32(mat_rd[31:0]);
        mul_b    = ext_dev(win_r[3'd3 - {1'b0, k_r[1:0]}]);
      end
      S_RSQ: begin
        mul_a = {1'b0, rm[31:0]};
        mul_b = {1'b0, rm[31:0]};
      end
      S_VARGO: begin
        div_start = 1'b1;
        div_num   = acc_r;
        div_den   = DDW'(m_cnt);
      end
      default: ;
    endcase
  end

  assign acc_sum  = {1'b0, acc_r} + {1'b0, p64};
  assign var_full = div_quo + 64'(div_rem >= DDW'(m_half));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mag_mem[count_r[AW-1:0]] <= sqrt_root;
    end
    mem_q_r <= mag_mem[rd_ptr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      rd_ptr_r    <= '0;
      res_pass_r  <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            axis_r[0] <= in_tdata[15:0];
            axis_r[1] <= in_tdata[31:16];
            axis_r[2] <= in_tdata[47:32];
            last_r    <= in_tlast;
            sq_acc_r  <= '0;
            k_r       <= '0;
            state_r   <= S_SQ;
          end
        end
        S_SQ: begin
          if (k_r != 5'd0) begin
            sq_acc_r <= sq_acc_r + p64[31:0];
          end
          k_r <= k_r + 1'b1;
          if (k_r == 5'd3) begin
            state_r <= S_ROOT_GO;
          end
        end
        S_ROOT_GO: state_r <= S_ROOT_WAIT;
        S_ROOT_WAIT: begin
          if (sqrt_done) begin
            if (count_r < CW'(WINDOW_MAX)) begin
              sum_r   <= sum_r + SUM_W'(sqrt_root);
              count_r <= count_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            state_r <= last_r ? S_FIT : S_IDLE;
          end
        end
        S_FIT: begin
          if (count_r <= CW'(LAGS + 2)) begin
            status_r <= ST_SHORT;
            var_r    <= '0;
            state_r  <= S_OUT;
          end else begin
            state_r <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (div_done) begin
            mean_r <= div_quo[DEV_W-2:0];
            for (int n = 0; n < 20; n++) begin
              mat_r[n] <= '0;
            end
            rd_ptr_r   <= '0;
            res_pass_r <= 1'b0;
            state_r    <= S_WRD;
          end
        end
        S_WRD: begin
          rd_ptr_r <= rd_ptr_r + 1'b1;
          state_r  <= S_WCAP;
        end
        S_WCAP: begin
          for (int n = 0; n < 4; n++) begin
            win_r[n] <= win_r[n+1];
          end
          win_r[4] <= dev_cap;
          k_r      <= '0;
          if (rd_ptr_r < CW'(LAGS + 1)) begin
            state_r <= S_WRD;
          end else if (res_pass_r) begin
            res_r   <= 64'(dev_cap) <<< QF;
            state_r <= S_RMUL;
          end else begin
            state_r <= S_NMUL;
          end
        end
        S_NMUL: state_r <= S_NACC;
        S_NACC: begin
          mat_r[k_r] <= mat_rd + p64;
          if (k_r == 5'd19) begin
            k_r     <= '0;
            top_r   <= '0;
            state_r <= (rd_ptr_r < count_r) ? S_WRD : S_MAX;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_NMUL;
          end
        end
        S_MAX: begin
          if (mag64(mat_rd) > top_r) begin
            top_r <= mag64(mat_rd);
          end
          if (k_r == 5'd19) begin
            k_r     <= '0;
            len_r   <= '0;
            state_r <= S_LEN;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_LEN: begin
          // bit length of the largest sum, one bit a cycle
          if (top_r != 64'd0) begin
            top_r <= top_r >> 1;
            len_r <= len_r + 1'b1;
          end else begin
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          mat_r[k_r] <= normalize(mat_rd, len_r);
          if (k_r == 5'd19) begin
            i_r     <= '0;
            state_r <= S_PIV;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_PIV: begin
          piv_r <= mat_rd[31:0];
          col_r <= {1'b0, i_r};
          if (mat_rd == 64'sd0) begin
            status_r <= ST_SINGULAR;
            var_r    <= '0;
            state_r  <= S_OUT;
          end else begin
            state_r <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          neg_r   <= mat_rd[31] ^ piv_r[31];
          state_r <= S_DIVWT;
        end
        S_DIVWT: begin
          if (div_done) begin
            mat_r[mat_addr] <= 64'(with_sign(div_quo, neg_r));
            if (col_r == 3'd4) begin
              row_r   <= '0;
              state_r <= S_FROW;
            end else begin
              col_r   <= col_r + 1'b1;
              state_r <= S_DIVGO;
            end
          end
        end
        S_FROW: begin
          if (row_r == i_r) begin
            if (row_r == 2'd3) begin
              // last pivot row: elimination done
              acc_r      <= '0;
              rd_ptr_r   <= '0;
              res_pass_r <= 1'b1;
              state_r    <= S_WRD;
            end else begin
              row_r <= row_r + 1'b1;
            end
          end else begin
            f_r     <= mat_rd[31:0];
            col_r   <= {1'b0, i_r};
            state_r <= S_EMUL;
          end
        end
        S_EMUL: state_r <= S_ESUB;
        S_ESUB: begin
          mat_r[mat_addr] <= 64'(sat31(e_diff));
          if (col_r == 3'd4) begin
            if (row_r == 2'd3) begin
              if (i_r == 2'd3) begin
                acc_r      <= '0;
                rd_ptr_r   <= '0;
                res_pass_r <= 1'b1;
                state_r    <= S_WRD;
              end else begin
                i_r     <= i_r + 1'b1;
                state_r <= S_PIV;
              end
            end else begin
              row_r   <= row_r + 1'b1;
              state_r <= S_FROW;
            end
          end else begin
            col_r   <= col_r + 1'b1;
            state_r <= S_EMUL;
          end
        end
        S_RMUL: state_r <= S_RACC;
        S_RACC: begin
          res_r <= res_r - p64;
          if (k_r == 5'd3) begin
            state_r <= S_RSQ;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_RMUL;
          end
        end
        S_RSQ: state_r <= S_RSQA;
        S_RSQA: begin
          acc_r   <= acc_sum[64] ? '1 : acc_sum[63:0];
          state_r <= (rd_ptr_r < count_r) ? S_WRD : S_VARGO;
        end
        S_VARGO: state_r <= S_VARWT;
        S_VARWT: begin
          if (div_done) begin
            var_r    <= (var_full > 64'({VAR_W{1'b1}})) ? '1 : var_full[VAR_W-1:0];
            status_r <= ST_DONE;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            for (int n = 0; n < 4; n++) begin
              out_coef_r[n] <= (status_r == ST_DONE) ? mat_r[16+n][31:0] : 32'd0;
            end
            out_var_r    <= var_r;
            out_status_r <= status_r;
            out_drop_r   <= ovf_r;
            out_valid_r  <= 1'b1;
            count_r      <= '0;
            sum_r        <= '0;
            ovf_r        <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_var_r, out_coef_r[3], out_coef_r[2], out_coef_r[1], out_coef_r[0]};
  assign out_tuser  = {out_drop_r, out_status_r};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("accepted a sample while still busy");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] != ST_DONE) |-> (out_tdata == '0))
    else $error("failed fit carries nonzero data");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(WINDOW_MAX))
    else $error("sample count beyond window capacity");

endmodule

// ----- src/ar4lsf_mul.sv -----
// ----------------------------------------------------------------------------
// ar4lsf_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module ar4lsf_mul (
  input  logic                                clk,
  input  logic signed [ar4lsf_pkg::MW-1:0]    op_a,
  input  logic signed [ar4lsf_pkg::MW-1:0]    op_b,
  output logic signed [ar4lsf_pkg::PW-1:0]    product
);
  import ar4lsf_pkg::*;

  logic signed [PW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign product = prod_r;

endmodule

// ----- src/ar4lsf_div.sv -----
// ----------------------------------------------------------------------------
// ar4lsf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ar4lsf_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [ar4lsf_pkg::DNW-1:0]      dividend,
  input  logic [ar4lsf_pkg::DDW-1:0]      divisor,
  output logic                            done,
  output logic [ar4lsf_pkg::DNW-1:0]      quotient,
  output logic [ar4lsf_pkg::DDW-1:0]      remainder
);
  import ar4lsf_pkg::*;

  logic [DNW-1:0]    dvd_r, dvd_nxt;
  logic [DDW-1:0]    rem_r, rem_nxt;
  logic [DDW-1:0]    den_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DDW:0]      trial;
  logic              qbit;

  always_comb begin
    trial = {rem_r, dvd_r[DNW-1]};
    qbit  = (trial >= {1'b0, den_r});
    if (qbit) begin
      rem_nxt = DDW'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[DDW-1:0];
    end
    dvd_nxt = {dvd_r[DNW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
      end else if (busy_r) begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DNW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

// ----- src/ar4lsf_isqrt.sv -----
// ----------------------------------------------------------------------------
// ar4lsf_isqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ar4lsf_isqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ar4lsf_pkg::SQW-1:0]        radicand,
  output logic                              done,
  output logic [ar4lsf_pkg::MAG_W-1:0]      root
);
  import ar4lsf_pkg::*;

  logic [SQW-1:0] v_r, v_nxt;
  logic [SQW-1:0] r_r, r_nxt;
  logic [SQW-1:0] bit_r;
  logic [SQW-1:0] trial;
  logic           busy_r, done_r;

  always_comb begin
    trial = r_r + bit_r;
    if (v_r >= trial) begin
      v_nxt = v_r - trial;
      r_nxt = (r_r >> 1) + bit_r;
    end else begin
      v_nxt = v_r;
      r_nxt = r_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        v_r    <= radicand;
        r_r    <= '0;
        bit_r  <= SQW'(1) << (SQW - 2);
      end else if (busy_r) begin
        v_r   <= v_nxt;
        r_r   <= r_nxt;
        bit_r <= bit_r >> 2;
        if (bit_r == SQW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[MAG_W-1:0];

endmodule
